[hw/rtl/pcf_pkg.sv]
// Positioner command framer: shared types, command codes and bus byte values.
// Used by every module of the block; depends on nothing.
`default_nettype none

package pcf_pkg;

  // Command kinds on the input channel
  localparam logic [3:0] KIND_DRIVE   = 4'd0;
  localparam logic [3:0] KIND_STEP    = 4'd1;
  localparam logic [3:0] KIND_HALT    = 4'd2;
  localparam logic [3:0] KIND_LIMIT   = 4'd3;
  localparam logic [3:0] KIND_DISABLE = 4'd4;
  localparam logic [3:0] KIND_ENABLE  = 4'd5;
  localparam logic [3:0] KIND_STORE   = 4'd6;
  localparam logic [3:0] KIND_RECALC  = 4'd7;
  localparam logic [3:0] KIND_GOTO    = 4'd8;
  localparam logic [3:0] KIND_ANGLE   = 4'd9;

  // Bus bytes
  localparam logic [7:0] FRAME_BYTE    = 8'hE0;
  localparam logic [7:0] ADDR_BYTE     = 8'h31;
  localparam logic [7:0] CMD_DRIVE_W   = 8'h68;
  localparam logic [7:0] CMD_DRIVE_E   = 8'h69;
  localparam logic [7:0] CMD_HALT      = 8'h60;
  localparam logic [7:0] CMD_LIMIT_W   = 8'h66;
  localparam logic [7:0] CMD_LIMIT_E   = 8'h67;
  localparam logic [7:0] CMD_DISABLE   = 8'h63;
  localparam logic [7:0] CMD_ENABLE    = 8'h6A;
  localparam logic [7:0] CMD_GOTO      = 8'h6B;
  localparam logic [7:0] CMD_RECALC    = 8'h6F;
  localparam logic [7:0] CMD_ANGLE     = 8'h6E;
  localparam logic [3:0] SIGN_NEG      = 4'hE;
  localparam logic [3:0] SIGN_POS      = 4'hD;

  localparam logic [6:0]  STEPS_MAX    = 7'd127;
  localparam logic [11:0] ANGLE_MAX    = 12'd2559;
  // floor(x / 10) == (x * DIV10_MUL) >> DIV10_SHIFT for x <= ANGLE_MAX
  localparam logic [12:0] DIV10_MUL    = 13'd6554;
  localparam int          DIV10_SHIFT  = 16;

  localparam int MAX_CMD   = 4;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [2:0]              n_cmd;   // command bytes, 1..4
    logic [MAX_CMD-1:0][7:0] cmd;
  } cmd_desc_t;

  // Rounded sixteenths of a tenth digit: (t * 16 + 5) / 10
  function automatic logic [3:0] tenth_to_sixteenth(input logic [3:0] t);
    logic [3:0] r;
    case (t)
      4'd0:    r = 4'h0;
      4'd1:    r = 4'h2;
      4'd2:    r = 4'h3;
      4'd3:    r = 4'h5;
      4'd4:    r = 4'h6;
      4'd5:    r = 4'h8;
      4'd6:    r = 4'hA;
      4'd7:    r = 4'hB;
      4'd8:    r = 4'hD;
      4'd9:    r = 4'hE;
      default: r = 4'h0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/pcf_front.sv]
// Positioner command framer front end: classifies an incoming command and
// builds its command bytes. Depends on pcf_pkg.
`default_nettype none

module pcf_front (
  input  wire logic [3:0]         kind_i,
  input  wire logic               direction_i,
  input  wire logic [7:0]         steps_i,
  input  wire logic [7:0]         slot_number_i,
  input  wire logic signed [12:0] hour_angle_i,
  output pcf_pkg::cmd_desc_t      desc_o,
  output logic                    emit_o
);

  logic        neg;
  logic [12:0] mag;
  logic [11:0] mag_sat;
  logic [24:0] prod;
  logic [7:0]  deg;
  logic [11:0] deg_x10;
  logic [3:0]  tenth;
  logic [6:0]  steps_sat;
  logic [7:0]  move_byte;

  always_comb begin
    neg = hour_angle_i[12];
    mag = neg ? (13'd0 - hour_angle_i) : hour_angle_i;
    // mag can reach 4096 for the most negative code
    if (mag > {1'b0, pcf_pkg::ANGLE_MAX}) begin
      mag_sat = pcf_pkg::ANGLE_MAX;
    end else begin
      mag_sat = mag[11:0];
    end
    prod    = {13'd0, mag_sat} * {12'd0, pcf_pkg::DIV10_MUL};
    deg     = prod[pcf_pkg::DIV10_SHIFT +: 8];
    deg_x10 = {1'b0, deg, 3'd0} + {3'd0, deg, 1'b0};
    tenth   = 4'(mag_sat - deg_x10);
  end

  always_comb begin
    steps_sat = (steps_i > {1'b0, pcf_pkg::STEPS_MAX}) ? pcf_pkg::STEPS_MAX : steps_i[6:0];
    move_byte = direction_i ? pcf_pkg::CMD_DRIVE_E : pcf_pkg::CMD_DRIVE_W;
  end

  always_comb begin
    desc_o.n_cmd = 3'd2;
    desc_o.cmd   = '0;
    emit_o       = 1'b1;
    case (kind_i)
      pcf_pkg::KIND_DRIVE: begin
        desc_o.cmd[0] = move_byte;
      end
      pcf_pkg::KIND_STEP: begin
        desc_o.cmd[0] = move_byte;
        desc_o.cmd[1] = 8'd0 - {1'b0, steps_sat};
        emit_o        = (steps_i != 8'd0);
      end
      pcf_pkg::KIND_HALT: begin
        desc_o.n_cmd  = 3'd1;
        desc_o.cmd[0] = pcf_pkg::CMD_HALT;
      end
      pcf_pkg::KIND_LIMIT: begin
        desc_o.n_cmd  = 3'd1;
        desc_o.cmd[0] = direction_i ? pcf_pkg::CMD_LIMIT_E : pcf_pkg::CMD_LIMIT_W;
      end
      pcf_pkg::KIND_DISABLE: begin
        desc_o.n_cmd  = 3'd1;
        desc_o.cmd[0] = pcf_pkg::CMD_DISABLE;
      end
      pcf_pkg::KIND_ENABLE: begin
        desc_o.cmd[0] = pcf_pkg::CMD_ENABLE;
      end
      pcf_pkg::KIND_STORE: begin
        desc_o.cmd[0] = pcf_pkg::CMD_ENABLE;
        desc_o.cmd[1] = slot_number_i;
      end
      pcf_pkg::KIND_RECALC: begin
        desc_o.n_cmd  = 3'd4;
        desc_o.cmd[0] = pcf_pkg::CMD_RECALC;
        desc_o.cmd[1] = slot_number_i;
      end
      pcf_pkg::KIND_GOTO: begin
        desc_o.cmd[0] = pcf_pkg::CMD_GOTO;
        desc_o.cmd[1] = slot_number_i;
      end
      pcf_pkg::KIND_ANGLE: begin
        desc_o.n_cmd  = 3'd3;
        desc_o.cmd[0] = pcf_pkg::CMD_ANGLE;
        desc_o.cmd[1] = {(neg ? pcf_pkg::SIGN_NEG : pcf_pkg::SIGN_POS), deg[7:4]};
        desc_o.cmd[2] = {deg[3:0], pcf_pkg::tenth_to_sixteenth(tenth)};
      end
      default: begin
        emit_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/pcf_queue.sv]
// Positioner command framer: short queue of command descriptors between the
// front end and the byte sequencer. Depends on pcf_pkg.
`default_nettype none

module pcf_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire pcf_pkg::cmd_desc_t desc_i,
  input  wire logic               pop_i,
  output logic                    full_o,
  output logic                    empty_o,
  output pcf_pkg::cmd_desc_t      head_o
);

  pcf_pkg::cmd_desc_t                entry_q [pcf_pkg::QDEPTH];
  logic [pcf_pkg::QPTR_W-1:0]        wr_q, wr_d, rd_q, rd_d;
  logic [pcf_pkg::QCNT_W-1:0]        cnt_q, cnt_d;

  function automatic logic [pcf_pkg::QPTR_W-1:0] ptr_inc(input logic [pcf_pkg::QPTR_W-1:0] p);
    logic [pcf_pkg::QPTR_W-1:0] r;
    if (p == pcf_pkg::QPTR_W'(pcf_pkg::QDEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign full_o  = (cnt_q == pcf_pkg::QCNT_W'(pcf_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = entry_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ptr_inc(wr_q) : wr_q;
    rd_d  = pop_i  ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= desc_i;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pcf_back.sv]
// Positioner command framer back end: walks the head descriptor byte by byte
// (frame, address, command bytes) into the output register. Depends on pcf_pkg.
`default_nettype none

module pcf_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               empty_i,
  input  wire pcf_pkg::cmd_desc_t head_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [7:0]              msg_byte_o,
  output logic                    last_o
);

  logic [2:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic       adv;
  logic       at_end;
  logic [1:0] sel;

  // output register may load when empty or being drained
  assign adv    = !valid_q || out_ready_i;
  assign at_end = (idx_q == head_i.n_cmd + 3'd1);
  assign sel    = 2'(idx_q - 3'd2);
  assign pop_o  = adv && !empty_i && at_end;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    if (adv) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        case (idx_q)
          3'd0:    byte_d = pcf_pkg::FRAME_BYTE;
          3'd1:    byte_d = pcf_pkg::ADDR_BYTE;
          default: byte_d = head_i.cmd[sel];
        endcase
        last_d = at_end;
        idx_d  = at_end ? 3'd0 : idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 3'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign msg_byte_o  = byte_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

[hw/rtl/positioner_command_framer_unit.sv]
// Positioner command framer top level: front end, descriptor queue and byte
// sequencer. Depends on pcf_pkg, pcf_front, pcf_queue, pcf_back.
//
// Usage
//   Input channel (in_valid_i/in_ready_o) takes one positioner command per
//   item: kind, direction, steps, slot number and hour angle in tenths.
//   Output channel (out_valid_o/out_ready_i) returns the bus message one
//   byte per item: 0xE0, 0x31, then one to four command bytes; last_o marks
//   the final byte. A step command with zero steps and unused kinds give
//   no bytes at all.
//   The first byte of a message passes the queue write, then the output
//   register, after its command is accepted. Throughput: one byte per cycle
//   on the output while the receiver is ready, so a command occupies the byte
//   sequencer for its whole message of 3 to 6 bytes; the front end takes a
//   command every cycle while the two-entry descriptor queue has room.
//   Reset empties the queue and the output register; nothing else is held.
//   When the receiver stalls, the current byte is held; the queue fills and
//   then in_ready_o falls until bytes drain again.
`default_nettype none

module positioner_command_framer_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [3:0]         kind_i,
  input  wire logic               direction_i,
  input  wire logic [7:0]         steps_i,
  input  wire logic [7:0]         slot_number_i,
  input  wire logic signed [12:0] hour_angle_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [7:0]              msg_byte_o,
  output logic                    last_o
);

  pcf_pkg::cmd_desc_t desc;
  pcf_pkg::cmd_desc_t head;
  logic               emit;
  logic               full;
  logic               empty;
  logic               push;
  logic               pop;

  pcf_front u_front (
    .kind_i        (kind_i),
    .direction_i   (direction_i),
    .steps_i       (steps_i),
    .slot_number_i (slot_number_i),
    .hour_angle_i  (hour_angle_i),
    .desc_o        (desc),
    .emit_o        (emit)
  );

  assign in_ready_o = !full;
  // commands that give no bytes are accepted and dropped
  assign push       = in_valid_i && in_ready_o && emit;

  pcf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (desc),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  pcf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .msg_byte_o  (msg_byte_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

[hw/rtl/pcf_checker.sv]
// Positioner command framer: port-level checks on the output channel and the
// message framing, bound to the top level. Depends on pcf_pkg.
`default_nettype none

module pcf_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] msg_byte_o,
  input wire logic       last_o
);

  logic       out_fire;
  logic [2:0] pos_q;

  assign out_fire = out_valid_o && out_ready_i;

  // position of the next byte within its message
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 3'd0;
    end else if (out_fire) begin
      pos_q <= last_o ? 3'd0 : pos_q + 3'd1;
    end
  end

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(msg_byte_o) && $stable(last_o))
    else $error("output item changed while stalled");

  a_frame_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && pos_q == 3'd0 |-> msg_byte_o == pcf_pkg::FRAME_BYTE && !last_o)
    else $error("message does not open with the framing byte");

  a_addr_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && pos_q == 3'd1 |-> msg_byte_o == pcf_pkg::ADDR_BYTE && !last_o)
    else $error("address byte missing");

  a_max_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && pos_q == 3'd5 |-> last_o)
    else $error("message longer than six bytes");

endmodule

bind positioner_command_framer_unit pcf_checker u_pcf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .msg_byte_o  (msg_byte_o),
  .last_o      (last_o)
);

`default_nettype wire

[tb/positioner_command_framer_unit_tb.sv]
// Self-checking testbench for positioner_command_framer_unit: a directed table of commands,
// then random commands, every bus byte checked against a typed message or a built-in framer.
// Depends on pcf_pkg and the positioner_command_framer_unit RTL.

module positioner_command_framer_unit_tb;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int TAIL_CYCLES     = 12;
  localparam int RANDOM_COMMANDS = 75;
  localparam int QUIET_FROM      = 60;
  localparam int HOLD_OFF_AT     = 30;
  localparam int PREDICTED       = -1;

  localparam logic [3:0] KIND_UNUSED_LO = 4'd10;
  localparam logic [3:0] KIND_UNUSED_HI = 4'd15;

  typedef struct packed {
    logic [3:0]         kind;
    logic               direction;
    logic [7:0]         steps;
    logic [7:0]         slot_number;
    logic signed [12:0] hour_angle;
  } command_t;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       last;
  } bus_byte_t;

  typedef struct {
    command_t    cmd;
    int          n_typed;    // message length, or PREDICTED
    logic [47:0] typed_msg;  // first byte in the top bits
  } directed_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [3:0]         kind_i;
  logic               direction_i;
  logic [7:0]         steps_i;
  logic [7:0]         slot_number_i;
  logic signed [12:0] hour_angle_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [7:0]         msg_byte_o;
  logic               last_o;

  bus_byte_t     pending_bytes [$];
  directed_row_t directed_rows [$];
  int            errors;
  int            idle_cycles;
  bit            quiet;
  bit            hold_off_request;

  positioner_command_framer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .direction_i   (direction_i),
    .steps_i       (steps_i),
    .slot_number_i (slot_number_i),
    .hour_angle_i  (hour_angle_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .msg_byte_o    (msg_byte_o),
    .last_o        (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void expect_byte(input logic [7:0] b, input logic l);
    bus_byte_t e;
    e.msg_byte = b;
    e.last     = l;
    pending_bytes.push_back(e);
  endfunction

  // Expected bus message for one command, appended to pending_bytes
  function automatic void frame_command(input command_t c);
    logic [7:0] body [$];
    logic [7:0] move;
    int         n_steps;
    int         mag;
    int         deg;
    int         tenth;
    bit         neg;
    move = c.direction ? pcf_pkg::CMD_DRIVE_E : pcf_pkg::CMD_DRIVE_W;
    case (c.kind)
      pcf_pkg::KIND_DRIVE: begin
        body.push_back(move);
        body.push_back(8'h00);
      end
      pcf_pkg::KIND_STEP: begin
        if (c.steps != 8'd0) begin
          n_steps = (c.steps > pcf_pkg::STEPS_MAX) ? int'(pcf_pkg::STEPS_MAX) : int'(c.steps);
          body.push_back(move);
          body.push_back(8'(256 - n_steps));
        end
      end
      pcf_pkg::KIND_HALT:    body.push_back(pcf_pkg::CMD_HALT);
      pcf_pkg::KIND_LIMIT:
        body.push_back(c.direction ? pcf_pkg::CMD_LIMIT_E : pcf_pkg::CMD_LIMIT_W);
      pcf_pkg::KIND_DISABLE: body.push_back(pcf_pkg::CMD_DISABLE);
      pcf_pkg::KIND_ENABLE: begin
        body.push_back(pcf_pkg::CMD_ENABLE);
        body.push_back(8'h00);
      end
      pcf_pkg::KIND_STORE: begin
        body.push_back(pcf_pkg::CMD_ENABLE);
        body.push_back(c.slot_number);
      end
      pcf_pkg::KIND_RECALC: begin
        body.push_back(pcf_pkg::CMD_RECALC);
        body.push_back(c.slot_number);
        body.push_back(8'h00);
        body.push_back(8'h00);
      end
      pcf_pkg::KIND_GOTO: begin
        body.push_back(pcf_pkg::CMD_GOTO);
        body.push_back(c.slot_number);
      end
      pcf_pkg::KIND_ANGLE: begin
        neg = (c.hour_angle < 0);
        mag = neg ? -int'(c.hour_angle) : int'(c.hour_angle);
        if (mag > int'(pcf_pkg::ANGLE_MAX)) mag = int'(pcf_pkg::ANGLE_MAX);
        deg   = mag / 10;
        tenth = mag % 10;
        body.push_back(pcf_pkg::CMD_ANGLE);
        body.push_back({neg ? pcf_pkg::SIGN_NEG : pcf_pkg::SIGN_POS, 4'(deg / 16)});
        // tenths digit rounded to sixteenths
        body.push_back({4'(deg % 16), 4'((tenth * 16 + 5) / 10)});
      end
      default: ;
    endcase
    if (body.size() > 0) begin
      expect_byte(pcf_pkg::FRAME_BYTE, 1'b0);
      expect_byte(pcf_pkg::ADDR_BYTE, 1'b0);
      foreach (body[i]) expect_byte(body[i], i == body.size() - 1);
    end
  endfunction

  function automatic void add_row(input logic [3:0] kind, input logic dir,
                                  input logic [7:0] steps, input logic [7:0] slot,
                                  input logic signed [12:0] angle, input int n,
                                  input logic [47:0] msg);
    directed_row_t r;
    r.cmd.kind        = kind;
    r.cmd.direction   = dir;
    r.cmd.steps       = steps;
    r.cmd.slot_number = slot;
    r.cmd.hour_angle  = angle;
    r.n_typed         = n;
    r.typed_msg       = msg;
    directed_rows.push_back(r);
  endfunction

  function automatic command_t random_command();
    command_t c;
    if ($urandom_range(0, 9) == 0) c.kind = 4'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
    else c.kind = 4'($urandom_range(pcf_pkg::KIND_DRIVE, pcf_pkg::KIND_ANGLE));
    c.direction = 1'($urandom);
    case ($urandom_range(0, 7))
      0:       c.steps = 8'd0;
      1:       c.steps = 8'($urandom_range(128, 255));
      default: c.steps = 8'($urandom_range(1, 127));
    endcase
    c.slot_number = 8'($urandom);
    if ($urandom_range(0, 1) == 0) c.hour_angle = 13'(int'($urandom_range(0, 5118)) - 2559);
    else c.hour_angle = 13'($urandom);
    return c;
  endfunction

  function automatic int sender_gap();
    if (quiet || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 9);
  endfunction

  // Offer one command and return just after the edge that accepts it
  task automatic offer_command(input command_t c, input int gap);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    kind_i        <= c.kind;
    direction_i   <= c.direction;
    steps_i       <= c.steps;
    slot_number_i <= c.slot_number;
    hour_angle_i  <= c.hour_angle;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic pause_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_bytes.size() == 0);
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_request) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk_i);
        hold_off_request = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    bus_byte_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected item: msg_byte %02h last %0b", msg_byte_o, last_o);
        errors++;
      end else begin
        want = pending_bytes.pop_front();
        if (msg_byte_o !== want.msg_byte) begin
          $error("msg_byte: expected %02h, got %02h", want.msg_byte, msg_byte_o);
          errors++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    command_t      c;
    directed_row_t row;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    kind_i           = pcf_pkg::KIND_DRIVE;
    direction_i      = 1'b0;
    steps_i          = 8'd0;
    slot_number_i    = 8'd0;
    hour_angle_i     = 13'sd0;
    errors           = 0;
    idle_cycles      = 0;
    quiet            = 1'b0;
    hold_off_request = 1'b0;

    //      kind                   dir   steps  slot   angle  len        message
    add_row(pcf_pkg::KIND_HALT,    1'b0, 8'h00, 8'h00,     0, 3,         48'hE0_31_60_00_00_00);
    add_row(pcf_pkg::KIND_DRIVE,   1'b0, 8'h00, 8'h00,     0, 4,         48'hE0_31_68_00_00_00);
    add_row(pcf_pkg::KIND_DRIVE,   1'b1, 8'hFF, 8'hFF,    -1, 4,         48'hE0_31_69_00_00_00);
    add_row(pcf_pkg::KIND_STEP,    1'b1, 8'h00, 8'h00,     0, 0,         48'h0);
    add_row(pcf_pkg::KIND_STEP,    1'b0, 8'h01, 8'h00,     0, 4,         48'hE0_31_68_FF_00_00);
    add_row(pcf_pkg::KIND_STEP,    1'b1, 8'h7F, 8'h00,     0, 4,         48'hE0_31_69_81_00_00);
    add_row(pcf_pkg::KIND_STEP,    1'b0, 8'h80, 8'h00,     0, 4,         48'hE0_31_68_81_00_00);
    add_row(pcf_pkg::KIND_STEP,    1'b1, 8'hFF, 8'hFF,    -1, 4,         48'hE0_31_69_81_00_00);
    add_row(pcf_pkg::KIND_LIMIT,   1'b0, 8'h00, 8'h00,     0, 3,         48'hE0_31_66_00_00_00);
    add_row(pcf_pkg::KIND_LIMIT,   1'b1, 8'h00, 8'h00,     0, 3,         48'hE0_31_67_00_00_00);
    add_row(pcf_pkg::KIND_DISABLE, 1'b1, 8'hFF, 8'hFF,    -1, 3,         48'hE0_31_63_00_00_00);
    add_row(pcf_pkg::KIND_ENABLE,  1'b1, 8'hFF, 8'hFF,    -1, 4,         48'hE0_31_6A_00_00_00);
    add_row(pcf_pkg::KIND_STORE,   1'b0, 8'h00, 8'h00,     0, 4,         48'hE0_31_6A_00_00_00);
    add_row(pcf_pkg::KIND_STORE,   1'b0, 8'h00, 8'hFF,     0, 4,         48'hE0_31_6A_FF_00_00);
    add_row(pcf_pkg::KIND_RECALC,  1'b0, 8'h00, 8'hA5,     0, 6,         48'hE0_31_6F_A5_00_00);
    add_row(pcf_pkg::KIND_GOTO,    1'b1, 8'h00, 8'h5A,     0, 4,         48'hE0_31_6B_5A_00_00);
    add_row(pcf_pkg::KIND_ANGLE,   1'b0, 8'h00, 8'h00,     0, 5,         48'hE0_31_6E_D0_00_00);
    add_row(pcf_pkg::KIND_ANGLE,   1'b0, 8'h00, 8'h00,  2559, 5,         48'hE0_31_6E_DF_FE_00);
    add_row(pcf_pkg::KIND_ANGLE,   1'b0, 8'h00, 8'h00, -2559, 5,         48'hE0_31_6E_EF_FE_00);
    // beyond the field range: magnitude saturates
    add_row(pcf_pkg::KIND_ANGLE,   1'b0, 8'h00, 8'h00, -4096, 5,         48'hE0_31_6E_EF_FE_00);
    add_row(pcf_pkg::KIND_ANGLE,   1'b1, 8'hFF, 8'hFF,  4095, 5,         48'hE0_31_6E_DF_FE_00);
    add_row(pcf_pkg::KIND_ANGLE,   1'b0, 8'h00, 8'h00,  1234, PREDICTED, 48'h0);
    add_row(pcf_pkg::KIND_ANGLE,   1'b0, 8'h00, 8'h00,    -5, PREDICTED, 48'h0);
    add_row(KIND_UNUSED_LO,        1'b1, 8'hFF, 8'hFF,    -1, 0,         48'h0);
    add_row(KIND_UNUSED_HI,        1'b0, 8'h01, 8'h01,     1, 0,         48'h0);

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      offer_command(row.cmd, sender_gap());
      if (row.n_typed == PREDICTED) begin
        frame_command(row.cmd);
      end else begin
        for (int k = 0; k < row.n_typed; k++)
          expect_byte(row.typed_msg[47 - 8 * k -: 8], k == row.n_typed - 1);
      end
    end

    // sender waits for the whole backlog before the random part
    pause_until_drained();

    for (int n = 0; n < RANDOM_COMMANDS; n++) begin
      if (n == HOLD_OFF_AT) hold_off_request = 1'b1;
      if (n >= QUIET_FROM) quiet = 1'b1;
      c = random_command();
      offer_command(c, sender_gap());
      frame_command(c);
    end

    pause_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending_bytes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
